// ----- rtl/weighted_centroid_centering_top_assert.svh -----
// assertion macros for the weighted centroid centering block
// used by wcc_dp and wcc_ctrl; needs i_clk and i_rst_n in scope
`ifndef WEIGHTED_CENTROID_CENTERING_TOP_ASSERT_SVH
`define WEIGHTED_CENTROID_CENTERING_TOP_ASSERT_SVH
`ifndef SYNTH
`define WCC_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("wcc check failed");
`define WCC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("wcc check failed");
`else
`define WCC_ASSERT_SAME(label, pre, post)
`define WCC_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/wcc_pkg.sv -----
// shared types, constants and helpers for the weighted centroid centering block
// no dependencies
`timescale 1ns / 1ps
package wcc_pkg;
    localparam int MAX_ATOMS_DEF = 64;
    localparam int COORD_W = 24;
    localparam int VAR_W   = 16;
    localparam int W_W     = 17;
    localparam int SUM_W   = 47;
    localparam int TOT_W   = 23;
    localparam int STEP_W  = 6;
    localparam logic [STEP_W-1:0] RECIP_STEPS = STEP_W'(W_W);
    localparam logic [STEP_W-1:0] CENT_STEPS  = STEP_W'(SUM_W);

    localparam logic [1:0] DSEL_RECIP = 2'd0;
    localparam logic [1:0] DSEL_X     = 2'd1;
    localparam logic [1:0] DSEL_Y     = 2'd2;
    localparam logic [1:0] DSEL_Z     = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       cap_w;
        logic       mul;
        logic       acc;
        logic       cap_cent;
        logic       rd_start;
        logic       rd_next;
        logic       emit;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic div_done;
        logic div_busy;
        logic out_taken;
        logic emit_last;
    } t_stat;

    function automatic logic signed [COORD_W-1:0] sat_diff(
        input logic signed [COORD_W:0] v);
        logic signed [COORD_W:0] hi;
        logic signed [COORD_W:0] lo;
        hi = (COORD_W+1)'(2**(COORD_W-1) - 1);
        lo = -(COORD_W+1)'(2**(COORD_W-1));
        if (v > hi) return hi[COORD_W-1:0];
        if (v < lo) return lo[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // signed quotient from sign and magnitude, clamped to coordinate range
    function automatic logic signed [COORD_W-1:0] sat_cent(
        input logic neg, input logic [SUM_W-1:0] mag);
        logic [SUM_W-1:0] lim_p;
        logic [SUM_W-1:0] sv;
        lim_p = SUM_W'(2**(COORD_W-1) - 1);
        if (!neg) begin
            if (mag > lim_p) return lim_p[COORD_W-1:0];
            return mag[COORD_W-1:0];
        end
        if (mag > lim_p + SUM_W'(1)) return {1'b1, {(COORD_W-1){1'b0}}};
        sv = ~mag + SUM_W'(1);
        return sv[COORD_W-1:0];
    endfunction
endpackage

// ----- rtl/weighted_centroid_centering_top.sv -----
// Weighted centroid centering. Input channel: i_valid / o_stall with one point per
// request (coordinates, variance, last flag). Output channel: o_valid / i_stall with
// one centered point per request. A request is taken at a clock edge with valid high
// and stall low.
// Each point in a set is taken, checked for a full store, passed through the shared
// restoring divider forming 65536/variance (17 steps, then a done strobe), then
// multiplied and accumulated.
// The request marked last then triggers three 47-step divisions for the centroid,
// after which the stored points are read from the point memory and sent in load order,
// each one read, registered for output and held until the receiver takes it.
// o_stall stays high from one accepted point until its work, and for the last point
// the whole emission, is finished; the block takes one point at a time.
// A held i_stall freezes the output register and the sequencer until it drops.
// Synchronous active-low reset clears the accumulators, point count and control;
// the point memory is not cleared and needs no clearing pass.
// Points beyond MAX_ATOMS in a set are dropped, but a last flag still closes it.
`timescale 1ns / 1ps
module weighted_centroid_centering_top import wcc_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic [VAR_W-1:0]          i_variance,
    input  logic                      i_last_point,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_centered_x,
    output logic signed [COORD_W-1:0] o_centered_y,
    output logic signed [COORD_W-1:0] o_centered_z,
    output logic signed [COORD_W-1:0] o_centroid_x,
    output logic signed [COORD_W-1:0] o_centroid_y,
    output logic signed [COORD_W-1:0] o_centroid_z,
    output logic                      o_last_result
);
    t_cmd  cmd;
    t_stat stat;

    wcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wcc_dp #(.MAX_ATOMS(MAX_ATOMS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_variance    (i_variance),
        .i_last_point  (i_last_point),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_centered_x  (o_centered_x),
        .o_centered_y  (o_centered_y),
        .o_centered_z  (o_centered_z),
        .o_centroid_x  (o_centroid_x),
        .o_centroid_y  (o_centroid_y),
        .o_centroid_z  (o_centroid_z),
        .o_last_result (o_last_result)
    );
endmodule

// ----- rtl/wcc_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on wcc_pkg
`timescale 1ns / 1ps
module wcc_div import wcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [TOT_W-1:0]  i_divisor,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_busy,
    output logic              o_done,
    output logic [SUM_W-1:0]  o_quot
);
    logic [TOT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [TOT_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [TOT_W:0]    trial;
    logic              bit_q;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        bit_q = (trial >= {1'b0, r_den});
        n_rem = bit_q ? TOT_W'(trial - {1'b0, r_den}) : trial[TOT_W-1:0];
        n_quo = {r_quo[SUM_W-2:0], bit_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ----- rtl/wcc_dp.sv -----
// datapath: input registers, point memory, accumulators, divider, output stage
// depends on wcc_pkg, wcc_div and the assertion header
`timescale 1ns / 1ps
`include "weighted_centroid_centering_top_assert.svh"
module wcc_dp import wcc_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic [VAR_W-1:0]          i_variance,
    input  logic                      i_last_point,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic signed [COORD_W-1:0] o_centered_x,
    output logic signed [COORD_W-1:0] o_centered_y,
    output logic signed [COORD_W-1:0] o_centered_z,
    output logic signed [COORD_W-1:0] o_centroid_x,
    output logic signed [COORD_W-1:0] o_centroid_y,
    output logic signed [COORD_W-1:0] o_centroid_z,
    output logic                      o_last_result
);
    localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);
    localparam int PRD_W = COORD_W + W_W + 1;

    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [VAR_W-1:0]          r_var;
    logic                      r_last;
    logic [W_W-1:0]            r_w;
    logic signed [PRD_W-1:0]   r_prx, r_pry, r_prz;
    logic signed [SUM_W-1:0]   r_sx, r_sy, r_sz;
    logic [TOT_W-1:0]          r_tot;
    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          r_rd_idx;
    logic [3*COORD_W-1:0]      r_mem [MAX_ATOMS];
    logic [3*COORD_W-1:0]      r_rd_data;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic                      r_valid;

    logic [SUM_W-1:0]   div_dvd;
    logic [TOT_W-1:0]   div_den;
    logic [STEP_W-1:0]  div_steps;
    logic               div_busy, div_done;
    logic [SUM_W-1:0]   div_q;
    logic signed [SUM_W-1:0] sel_sum;
    logic               sum_neg;
    logic signed [COORD_W-1:0] cent;
    logic signed [COORD_W-1:0] mx, my, mz;
    logic signed [W_W:0] w_s;

    always_comb begin
        unique case (i_cmd.div_sel)
            DSEL_X:  sel_sum = r_sx;
            DSEL_Y:  sel_sum = r_sy;
            DSEL_Z:  sel_sum = r_sz;
            default: sel_sum = '0;
        endcase
        sum_neg = sel_sum[SUM_W-1];
        if (i_cmd.div_sel == DSEL_RECIP) begin
            // 65536 left aligned so only the top bits are shifted through
            div_dvd   = {1'b1, {(SUM_W-1){1'b0}}};
            div_den   = (r_var == '0) ? TOT_W'(1) : TOT_W'(r_var);
            div_steps = RECIP_STEPS;
        end else begin
            div_dvd   = sum_neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
            div_den   = r_tot;
            div_steps = CENT_STEPS;
        end
        cent = (r_tot == '0) ? '0 : sat_cent(sum_neg, div_q);
        w_s  = $signed({1'b0, r_w});
        mx   = $signed(r_rd_data[3*COORD_W-1:2*COORD_W]);
        my   = $signed(r_rd_data[2*COORD_W-1:COORD_W]);
        mz   = $signed(r_rd_data[COORD_W-1:0]);
    end

    wcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_den),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_var  <= i_variance;
            r_last <= i_last_point;
        end
        if (i_cmd.cap_w) begin
            r_w <= div_q[W_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prx <= PRD_W'(r_px * w_s);
            r_pry <= PRD_W'(r_py * w_s);
            r_prz <= PRD_W'(r_pz * w_s);
        end
        if (i_cmd.cap_cent) begin
            unique case (i_cmd.div_sel)
                DSEL_X:  r_cx <= cent;
                DSEL_Y:  r_cy <= cent;
                DSEL_Z:  r_cz <= cent;
                default: r_cx <= r_cx;
            endcase
        end
        if (i_cmd.emit) begin
            o_centered_x  <= sat_diff((COORD_W+1)'(mx) - (COORD_W+1)'(r_cx));
            o_centered_y  <= sat_diff((COORD_W+1)'(my) - (COORD_W+1)'(r_cy));
            o_centered_z  <= sat_diff((COORD_W+1)'(mz) - (COORD_W+1)'(r_cz));
            o_centroid_x  <= r_cx;
            o_centroid_y  <= r_cy;
            o_centroid_z  <= r_cz;
            o_last_result <= o_stat.emit_last;
        end
    end

    // point memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_px, r_py, r_pz};
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // accumulators and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= '0;
            r_tot    <= '0;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_sx    <= '0;
                r_sy    <= '0;
                r_sz    <= '0;
                r_tot   <= '0;
                r_count <= '0;
            end else if (i_cmd.acc) begin
                r_sx    <= r_sx + SUM_W'(r_prx);
                r_sy    <= r_sy + SUM_W'(r_pry);
                r_sz    <= r_sz + SUM_W'(r_prz);
                r_tot   <= r_tot + TOT_W'(r_w);
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_stat.full      = (r_count == CNT_W'(MAX_ATOMS));
    assign o_stat.last      = r_last;
    assign o_stat.div_done  = div_done;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_taken = r_valid && !i_stall;
    assign o_stat.emit_last = (CNT_W'(r_rd_idx) + CNT_W'(1) == r_count);

    `WCC_ASSERT_SAME(a_count_range, 1'b1, r_count <= CNT_W'(MAX_ATOMS))
    `WCC_ASSERT_SAME(a_total_nonzero, r_count != '0, r_tot != '0)
    `WCC_ASSERT_SAME(a_start_idle, i_cmd.div_start, !div_busy)
    `WCC_ASSERT_NEXT(a_emit_valid, i_cmd.emit, r_valid)
endmodule

// ----- rtl/wcc_ctrl.sv -----
// controller state machine: sequences loading, division and emission
// depends on wcc_pkg and the assertion header
`timescale 1ns / 1ps
`include "weighted_centroid_centering_top_assert.svh"
module wcc_ctrl import wcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RECIP = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DGO   = 4'd5;
    localparam logic [3:0] S_DWAIT = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_LOAD  = 4'd8;
    localparam logic [3:0] S_SEND  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.full) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_RECIP;
                    n_state         = S_RECIP;
                end else if (i_stat.last) begin
                    n_sel   = DSEL_X;
                    n_state = S_DGO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RECIP: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_w = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_sel     = DSEL_X;
                n_state   = i_stat.last ? S_DGO : S_IDLE;
            end
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_cent = 1'b1;
                    if (r_sel == DSEL_Z) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_RD;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_DGO;
                    end
                end
            end
            S_RD: begin
                // read data lands at the end of this cycle
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.emit = 1'b1;
                n_state    = S_SEND;
            end
            S_SEND: begin
                if (i_stat.out_taken) begin
                    if (i_stat.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DSEL_X;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    `WCC_ASSERT_SAME(a_idle_no_div, r_state == S_IDLE, !i_stat.div_busy)
    `WCC_ASSERT_NEXT(a_load_leaves_idle, o_cmd.load, r_state == S_CHECK)
endmodule
